// ----- hw/rtl/ors_pkg.sv -----
// Package for the overwriting ring store.
// Holds the operation and status codes and the cell-control codes shared with the cell.
// Depends on nothing.
package ors_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int CFG_RESET       = 16;

  localparam int OP_W     = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;
  localparam int CFG_W    = 5;

  localparam logic [OP_W-1:0] OP_PUSH        = 3'd0;
  localparam logic [OP_W-1:0] OP_SET         = 3'd1;
  localparam logic [OP_W-1:0] OP_GET         = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE      = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP_OLDEST = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP_NEWEST = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] SRC_LOAD = 2'd0;
  localparam logic [1:0] SRC_UP   = 2'd1;
  localparam logic [1:0] SRC_DOWN = 2'd2;

  typedef struct packed {
    logic       en;
    logic [1:0] src;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/ors_cell.sv -----
// One storage cell of the ring store chain.
// Holds one entry and takes a new value from the load bus or from a neighbor.
// Depends on ors_pkg.
module ors_cell #(
  parameter int ENTRY_WIDTH = ors_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  ors_pkg::cell_ctl_t     ctl,
  input  logic [ENTRY_WIDTH-1:0] load_data,
  input  logic [ENTRY_WIDTH-1:0] up_data,
  input  logic [ENTRY_WIDTH-1:0] down_data,
  output logic [ENTRY_WIDTH-1:0] data_q
);
  import ors_pkg::*;

  logic [ENTRY_WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      unique case (ctl.src)
        SRC_LOAD: data_r <= load_data;
        SRC_UP:   data_r <= up_data;
        SRC_DOWN: data_r <= down_data;
        default:  data_r <= data_r;
      endcase
    end
  end

  assign data_q = data_r;

endmodule

// ----- hw/rtl/overwriting_ring_store.sv -----
// Overwriting ring store: a chain of cells where cell k holds logical entry k, oldest at 0.
// Every op except a non-empty dump gives one result, registered in the cycle after acceptance.
// A dump of n entries rotates the chain once per beat and gives n beats, one per cycle while the output is not stalled.
// Throughput is one item per cycle while the output is not stalled; no new item is taken while a dump is in progress.
// Reset is synchronous and clears the count and control state; cell contents are not reset.
// Depends on ors_pkg and ors_cell.
module overwriting_ring_store #(
  parameter int ENTRY_WIDTH = ors_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ors_pkg::OP_W-1:0]      in_op,
  input  logic [ors_pkg::POS_W-1:0]     in_position,
  input  logic [ENTRY_WIDTH-1:0]        in_entry_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ENTRY_WIDTH-1:0]        out_read_data,
  output logic [ors_pkg::POS_W-1:0]     out_read_position,
  output logic [ors_pkg::STATUS_W-1:0]  out_status,
  output logic [ors_pkg::FILL_W-1:0]    out_fill_count,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ors_pkg::CFG_W-1:0]     cfg_data
);
  import ors_pkg::*;

  localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int LEN_RST = (MAX_ENTRIES < CFG_RESET) ? MAX_ENTRIES : CFG_RESET;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                   state_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [CNT_W-1:0]       len_r;
  logic [CNT_W-1:0]       cfg_len;
  logic [CNT_W-1:0]       idx_r;
  logic                   dir_r;

  logic                   out_valid_r;
  logic [ENTRY_WIDTH-1:0] out_data_r;
  logic [POS_W-1:0]       out_pos_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [FILL_W-1:0]      out_fill_r;
  logic                   out_last_r;

  logic                   in_acc;
  logic                   out_free;
  logic                   cfg_wr;
  logic                   full;
  logic                   in_range;
  logic                   dump_step;
  logic                   dump_last;
  logic                   dump_start;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENTRY_WIDTH-1:0] rd_data;
  logic [ENTRY_WIDTH-1:0] load_data;

  logic                   emit_v;
  logic [ENTRY_WIDTH-1:0] emit_data;
  logic [POS_W-1:0]       emit_pos;
  logic [STATUS_W-1:0]    emit_status;
  logic                   emit_last;

  logic [ENTRY_WIDTH-1:0] cell_q [MAX_ENTRIES];
  cell_ctl_t              cell_ctl [MAX_ENTRIES];

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign full      = (count_r == len_r);
  assign in_range  = 32'(in_position) < 32'(count_r);
  assign dump_step = (state_r == ST_DUMP) && out_free;
  assign dump_last = (idx_r == count_r - 1'b1);
  assign dump_start = in_acc && ((in_op == OP_DUMP_OLDEST) || (in_op == OP_DUMP_NEWEST))
                      && (count_r != '0);

  always_comb begin
    if (32'(cfg_data) > 32'(MAX_ENTRIES)) begin
      cfg_len = CNT_W'(MAX_ENTRIES);
    end else if (cfg_data == '0) begin
      cfg_len = CNT_W'(1);
    end else begin
      cfg_len = CNT_W'(cfg_data);
    end
  end

  always_comb begin
    if (state_r == ST_DUMP) begin
      rd_addr = dir_r ? IDX_W'(count_r - 1'b1) : '0;
    end else begin
      rd_addr = IDX_W'(in_position);
    end
  end

  assign rd_data   = cell_q[rd_addr];
  assign load_data = dump_step ? rd_data : in_entry_data;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] up_data;
    logic [ENTRY_WIDTH-1:0] down_data;

    if (k < MAX_ENTRIES - 1) begin : g_up
      assign up_data = cell_q[k+1];
    end else begin : g_up_end
      assign up_data = '0;
    end

    if (k > 0) begin : g_down
      assign down_data = cell_q[k-1];
    end else begin : g_down_end
      assign down_data = '0;
    end

    always_comb begin
      cell_ctl[k] = '{en: 1'b0, src: SRC_LOAD};
      if (dump_step) begin
        if (!dir_r) begin
          if (k + 1 < 32'(count_r)) begin
            cell_ctl[k] = '{en: 1'b1, src: SRC_UP};
          end else if (k + 1 == 32'(count_r)) begin
            cell_ctl[k] = '{en: 1'b1, src: SRC_LOAD};
          end
        end else begin
          if (k == 0) begin
            cell_ctl[k] = '{en: 1'b1, src: SRC_LOAD};
          end else if (k < 32'(count_r)) begin
            cell_ctl[k] = '{en: 1'b1, src: SRC_DOWN};
          end
        end
      end else if (in_acc) begin
        unique case (in_op)
          OP_PUSH: begin
            if (full) begin
              if (k + 1 < 32'(len_r)) begin
                cell_ctl[k] = '{en: 1'b1, src: SRC_UP};
              end else if (k + 1 == 32'(len_r)) begin
                cell_ctl[k] = '{en: 1'b1, src: SRC_LOAD};
              end
            end else if (k == 32'(count_r)) begin
              cell_ctl[k] = '{en: 1'b1, src: SRC_LOAD};
            end
          end
          OP_SET: begin
            if (in_range && (k == 32'(in_position))) begin
              cell_ctl[k] = '{en: 1'b1, src: SRC_LOAD};
            end
          end
          OP_DELETE: begin
            if (in_range && (k >= 32'(in_position)) && (k + 1 < 32'(count_r))) begin
              cell_ctl[k] = '{en: 1'b1, src: SRC_UP};
            end
          end
          default: begin
            cell_ctl[k] = '{en: 1'b0, src: SRC_LOAD};
          end
        endcase
      end
    end

    ors_cell #(
      .ENTRY_WIDTH(ENTRY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[k]),
      .load_data (load_data),
      .up_data   (up_data),
      .down_data (down_data),
      .data_q    (cell_q[k])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      unique case (in_op)
        OP_PUSH:   count_nxt = full ? count_r : count_r + 1'b1;
        OP_DELETE: count_nxt = in_range ? count_r - 1'b1 : count_r;
        OP_CLEAR:  count_nxt = '0;
        default:   count_nxt = count_r;
      endcase
    end
    if (cfg_wr && (cfg_len != len_r)) begin
      count_nxt = '0;
    end
  end

  always_comb begin
    emit_v      = 1'b0;
    emit_data   = '0;
    emit_pos    = '0;
    emit_status = ST_OK;
    emit_last   = 1'b1;
    if (dump_step) begin
      emit_v    = 1'b1;
      emit_data = rd_data;
      emit_pos  = dir_r ? POS_W'(count_r - 1'b1 - idx_r) : POS_W'(idx_r);
      emit_last = dump_last;
    end else if (in_acc) begin
      emit_v = 1'b1;
      unique case (in_op)
        OP_PUSH: begin
          emit_pos = POS_W'(count_nxt - 1'b1);
        end
        OP_SET, OP_DELETE: begin
          emit_pos    = in_position;
          emit_status = in_range ? ST_OK : ST_RANGE;
        end
        OP_GET: begin
          emit_pos    = in_position;
          emit_status = in_range ? ST_OK : ST_RANGE;
          emit_data   = in_range ? rd_data : '0;
        end
        OP_DUMP_OLDEST, OP_DUMP_NEWEST: begin
          emit_v      = (count_r == '0);
          emit_status = ST_EMPTY;
        end
        default: begin
          emit_pos = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      len_r       <= CNT_W'(LEN_RST);
      idx_r       <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr) begin
        len_r <= cfg_len;
      end
      if (out_free) begin
        out_valid_r <= emit_v;
      end
      if (dump_start) begin
        state_r <= ST_DUMP;
        idx_r   <= '0;
        dir_r   <= (in_op == OP_DUMP_NEWEST);
      end else if (dump_step) begin
        idx_r <= idx_r + 1'b1;
        if (dump_last) begin
          state_r <= ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit_v) begin
      out_data_r   <= emit_data;
      out_pos_r    <= emit_pos;
      out_status_r <= emit_status;
      out_fill_r   <= FILL_W'(count_nxt);
      out_last_r   <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_data_r;
  assign out_read_position = out_pos_r;
  assign out_status        = out_status_r;
  assign out_fill_count    = out_fill_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  a_count_le_len : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= len_r)
    else $error("entry count exceeds ring length");

  a_dump_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> ((count_r != '0) && (idx_r < count_r)))
    else $error("dump index outside the held entries");

  a_accept_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid_r || (state_r == ST_DUMP)))
    else $error("accepted item produced neither a result nor a dump");

  a_dump_end_last : assert property (@(posedge clk) disable iff (!rst_n)
    (dump_step && dump_last) |=> (out_valid_r && out_last_r && (state_r == ST_IDLE)))
    else $error("final dump beat not marked last");
`endif

endmodule
